// ----- hw/rtl/dcr_pkg.sv -----
package dcr_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int ANSWER_BYTES = 16;
  localparam int ANS_IDX_W    = 4;

  // parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_NAME   = 2'd1;
  localparam logic [1:0] PH_TAIL   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // what one accepted query byte asks the output side to send
  typedef struct packed {
    logic       echo;       // send echo_byte first
    logic [7:0] echo_byte;
    logic       tail;       // datagram ended: answer or drop follows
    logic       tail_drop;  // tail is a single drop word
  } job_t;

  function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                             input logic [31:0] ip);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'hC0;
      4'd1:    r = 8'h0C;
      4'd3:    r = 8'h01;
      4'd5:    r = 8'h01;
      4'd9:    r = 8'h0A;
      4'd11:   r = 8'h04;
      4'd12:   r = ip[31:24];
      4'd13:   r = ip[23:16];
      4'd14:   r = ip[15:8];
      4'd15:   r = ip[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/dcr_parser.sv -----
module dcr_parser
  import dcr_pkg::*;
#(
  parameter int BUF_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       job_valid,
  output job_t       job,
  input  logic       job_take
);

  localparam int POS_W = $clog2(BUF_BYTES + 1);
  localparam int LBL_W = $clog2(BUF_BYTES + 257);

  logic [POS_W-1:0] bp, bp_next;
  logic [1:0]       phase, phase_next;
  logic [LBL_W-1:0] nlp, nlp_next;
  logic [LBL_W-1:0] qend, qend_next;
  logic             ar, ar_next;
  logic [15:0]      qc, qc_next;
  logic             mal, mal_next;

  logic             echo;
  logic [7:0]       ob;
  logic             ok;
  logic             accept;
  job_t             job_new;

  assign in_ready = !job_valid || job_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    bp_next    = bp;
    phase_next = phase;
    nlp_next   = nlp;
    qend_next  = qend;
    ar_next    = ar;
    qc_next    = qc;
    mal_next   = mal;
    echo       = 1'b0;
    ob         = in_byte;
    if (bp < POS_W'(BUF_BYTES)) begin
      case (phase)
        PH_HEADER: begin
          echo = 1'b1;
          if (bp == POS_W'(2)) begin
            ar_next = in_byte[7];
            if (!in_byte[7]) ob = in_byte | 8'h84;
          end else if (bp == POS_W'(4)) begin
            qc_next[15:8] = in_byte;
          end else if (bp == POS_W'(5)) begin
            qc_next[7:0] = in_byte;
          end else if (!ar) begin
            if (bp == POS_W'(6)) ob = qc[15:8];
            else if (bp == POS_W'(7)) ob = qc[7:0];
            else if (bp >= POS_W'(8) && bp <= POS_W'(11)) ob = 8'h00;
          end
          if (bp >= POS_W'(HEADER_BYTES - 1)) phase_next = PH_NAME;
        end
        PH_NAME: begin
          echo = 1'b1;
          if (LBL_W'(bp) == nlp) begin
            if (in_byte == 8'h00) begin
              qend_next  = LBL_W'(bp) + LBL_W'(5);
              phase_next = PH_TAIL;
              if ({1'b0, qend_next} + (LBL_W+1)'(ANSWER_BYTES) > (LBL_W+1)'(BUF_BYTES))
                mal_next = 1'b1;
            end else begin
              nlp_next = LBL_W'(bp) + LBL_W'(in_byte) + LBL_W'(1);
            end
          end
        end
        PH_TAIL: begin
          if (LBL_W'(bp) < qend) echo = 1'b1;
          else phase_next = PH_DONE;
        end
        default: ;
      endcase
      bp_next = bp + POS_W'(1);
    end
    ok = (phase_next == PH_TAIL || phase_next == PH_DONE) &&
         (qend_next <= LBL_W'(bp_next)) && !mal_next;
    if (in_last) begin
      bp_next    = '0;
      phase_next = PH_HEADER;
      nlp_next   = LBL_W'(HEADER_BYTES);
      qend_next  = '0;
      ar_next    = 1'b0;
      qc_next    = '0;
      mal_next   = 1'b0;
    end
    job_new.echo      = echo && !(in_last && !ok);
    job_new.echo_byte = ob;
    job_new.tail      = in_last;
    job_new.tail_drop = !ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp    <= '0;
      phase <= PH_HEADER;
      nlp   <= LBL_W'(HEADER_BYTES);
      qend  <= '0;
      ar    <= 1'b0;
      qc    <= '0;
      mal   <= 1'b0;
    end else if (accept) begin
      bp    <= bp_next;
      phase <= phase_next;
      nlp   <= nlp_next;
      qend  <= qend_next;
      ar    <= ar_next;
      qc    <= qc_next;
      mal   <= mal_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && (job_new.echo || job_new.tail)) begin
      job_valid <= 1'b1;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) job <= job_new;
  end

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_take |=> job_valid && $stable(job))
    else $error("pending job lost or changed while waiting");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    bp <= POS_W'(BUF_BYTES))
    else $error("byte position beyond buffer");

endmodule

// ----- hw/rtl/dcr_emitter.sv -----
module dcr_emitter
  import dcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  input  logic [31:0] ip,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_drop
);

  logic                 cur_valid;
  job_t                 cur;
  logic [ANS_IDX_W-1:0] cnt;
  logic                 fire;
  logic                 done_now;

  assign out_valid = cur_valid;
  assign fire      = cur_valid && out_ready;

  always_comb begin
    if (cur.echo) begin
      out_byte = cur.echo_byte;
      out_last = 1'b0;
      out_drop = 1'b0;
    end else if (cur.tail_drop) begin
      out_byte = 8'h00;
      out_last = 1'b1;
      out_drop = 1'b1;
    end else begin
      out_byte = answer_byte(cnt, ip);
      out_last = (cnt == ANS_IDX_W'(ANSWER_BYTES - 1));
      out_drop = 1'b0;
    end
  end

  // the word on the port is the job's final one
  assign done_now = fire && (cur.echo ? !cur.tail : (cur.tail_drop || out_last));
  assign job_take = job_valid && (!cur_valid || done_now);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
    end else if (job_take) begin
      cur_valid <= 1'b1;
      cnt       <= '0;
    end else if (done_now) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
    end else if (fire && !cur.echo) begin
      cnt <= cnt + ANS_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) cur <= job;
    else if (fire && cur.echo) cur.echo <= 1'b0;
  end

  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_drop |-> out_last)
    else $error("drop word without last mark");

  a_cnt_answer: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> cur_valid && cur.tail && !cur.tail_drop && !cur.echo)
    else $error("answer counter running outside an answer");

endmodule

// ----- hw/rtl/dns_captive_responder.sv -----
// Path: a result word passes through the parser's job slot and then the
//   emitter's current-job register before it is offered on the output.
// Throughput: one query byte per cycle while the job slot has room; the final byte
//   of a valid query yields its echo, if any, plus the 16-byte answer, so the
//   output side stays busy and the input stalls once the one-word job slot is full.
// Reset (rst, synchronous, active high): clears parse state, queued words and
//   the answer address to 0; no clearing pass, ready in the next cycle.
module dns_captive_responder
  import dcr_pkg::*;
#(
  parameter int BUF_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  // query byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // response byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // out_last
  output logic        m_axis_tuser,   // [0] drop
  // ap_ip_address write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] ap_ip;
  logic        job_valid;
  logic        job_take;
  job_t        job;

  // Address register: to be written only while the block is idle, so that a write lands
  // between datagrams; the block itself does not enforce this. Always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ap_ip <= '0;
    end else if (cfg_valid) begin
      ap_ip <= cfg_data;
    end
  end

  // Parse each byte against the header and question layout, rewrite the
  // header flags and counts on the fly, and hold the resulting job in a
  // one-word slot so the input can take one more byte while the output waits.
  dcr_parser #(
    .BUF_BYTES (BUF_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  // Send the echo word, then on a datagram end either the A record (sixteen
  // words, counted out) or a single drop word.
  dcr_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .ip        (ap_ip),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_drop  (m_axis_tuser)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import dcr_pkg::*;

  localparam int BUF_BYTES     = 128;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int TOTAL_BYTES   = 420;
  localparam int SETTLE_CYCLES = 8;

  // one query byte as presented on the slave side
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } query_word_t;

  // one response word as expected on the master side
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drop;
  } reply_word_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0;    // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;            // [7:0] out_byte
  logic        m_axis_tlast;            // out_last
  logic        m_axis_tuser;            // [0] drop
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data      = 32'h0;

  query_word_t query_words[$];    // bytes waiting to be offered
  reply_word_t awaited_words[$];  // response words not yet seen
  logic [7:0]  pkt[$];            // datagram under construction

  int idle_pct  = 33;
  int cycle     = 0;
  int errors    = 0;
  int fed_bytes = 0;

  // shadow of the responder's state
  logic [31:0] answer_ip = 32'h0;
  logic [10:0] rx_pos;
  logic [10:0] label_pos;
  logic [10:0] qend_pos;
  logic [1:0]  parse_phase;
  logic        was_response;
  logic        malformed;
  logic [15:0] qd_count;

  dns_captive_responder #(
    .BUF_BYTES(BUF_BYTES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR cycle %0d: %s", cycle, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Response prediction
  // ---------------------------------------------------------------------------

  task automatic restart_query();
    rx_pos       = 11'd0;
    parse_phase  = PH_HEADER;
    label_pos    = 11'(HEADER_BYTES);
    qend_pos     = 11'd0;
    was_response = 1'b0;
    malformed    = 1'b0;
    qd_count     = 16'h0;
  endtask

  // fixed part of the A record, then the address with its top octet first
  function automatic logic [7:0] answer_octet(input int idx);
    case (idx)
      0:       return 8'hC0;
      1:       return 8'h0C;
      3, 5:    return 8'h01;
      9:       return 8'h0A;
      11:      return 8'h04;
      12, 13, 14, 15: return answer_ip[8*(15-idx) +: 8];
      default: return 8'h00;
    endcase
  endfunction

  task automatic predict_reply(input query_word_t w);
    logic [7:0]  echo_byte;
    logic        echo;
    logic        answer_ok;
    logic        is_final;
    reply_word_t word;
    int          pos;
    int          i;
    echo      = 1'b0;
    echo_byte = w.data;
    pos       = int'(rx_pos);
    if (pos < BUF_BYTES) begin
      case (parse_phase)
        PH_HEADER: begin
          echo = 1'b1;
          // a query gets QR and AA set, ANCOUNT from QDCOUNT, NS and AR counts cleared;
          // a datagram that already claims to be a response passes unchanged
          case (pos)
            2: begin
              was_response = w.data[7];
              if (!was_response)
                echo_byte = w.data | 8'h84;
            end
            4: qd_count[15:8] = w.data;
            5: qd_count[7:0]  = w.data;
            6: if (!was_response) echo_byte = qd_count[15:8];
            7: if (!was_response) echo_byte = qd_count[7:0];
            8, 9, 10, 11: if (!was_response) echo_byte = 8'h00;
            default: ;
          endcase
          if (pos == HEADER_BYTES - 1)
            parse_phase = PH_NAME;
        end
        PH_NAME: begin
          echo = 1'b1;
          // only the length bytes steer the walk; label contents are opaque
          if (pos == int'(label_pos)) begin
            if (w.data == 8'h00) begin
              qend_pos    = 11'(pos + 5);
              parse_phase = PH_TAIL;
              if (pos + 5 + ANSWER_BYTES > BUF_BYTES)
                malformed = 1'b1;
            end else begin
              label_pos = 11'(pos + int'(w.data) + 1);
            end
          end
        end
        PH_TAIL: begin
          if (pos < int'(qend_pos))
            echo = 1'b1;
          else
            parse_phase = PH_DONE;
        end
        default: ;
      endcase
      rx_pos = rx_pos + 11'd1;
    end

    word = '{echo_byte, 1'b0, 1'b0};
    if (w.last) begin
      answer_ok = (parse_phase == PH_TAIL || parse_phase == PH_DONE) &&
                  qend_pos <= rx_pos && !malformed;
      if (answer_ok) begin
        if (echo)
          awaited_words.push_back(word);
        for (i = 0; i < ANSWER_BYTES; i++) begin
          is_final = (i == ANSWER_BYTES - 1);
          awaited_words.push_back('{answer_octet(i), is_final, 1'b0});
        end
      end else begin
        // a dropped datagram ends in one drop word; the closing byte is not echoed
        awaited_words.push_back('{8'h00, 1'b1, 1'b1});
      end
      restart_query();
    end else if (echo) begin
      awaited_words.push_back(word);
    end
  endtask

  task automatic check_reply();
    reply_word_t want;
    if (awaited_words.size() == 0) begin
      flag_error($sformatf("unexpected word %02h last %0b drop %0b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser));
    end else begin
      want = awaited_words.pop_front();
      if (m_axis_tdata !== want.data)
        flag_error($sformatf("out_byte %02h, want %02h", m_axis_tdata, want.data));
      if (m_axis_tlast !== want.last)
        flag_error($sformatf("out_last %0b, want %0b (byte %02h)",
                             m_axis_tlast, want.last, want.data));
      if (m_axis_tuser !== want.drop)
        flag_error($sformatf("drop %0b, want %0b", m_axis_tuser, want.drop));
    end
  endtask

  // Monitor: shadow every accepted query byte, then check every accepted response word.
  always @(posedge clk) begin
    if (rst) begin
      restart_query();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        predict_reply('{s_axis_tdata, s_axis_tlast});
      if (m_axis_tvalid && m_axis_tready)
        check_reply();
    end
  end

  // Driver: offer the next byte when the slot is free, and stall the response side at random.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (query_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid                <= 1'b1;
          {s_axis_tdata, s_axis_tlast} <= query_words.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing word ends the run here.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Datagram construction
  // ---------------------------------------------------------------------------

  task automatic add_random(input int n);
    int i;
    for (i = 0; i < n; i++)
      pkt.push_back(8'($urandom));
  endtask

  task automatic start_header(input logic resp);
    logic [7:0] b;
    int         i;
    pkt.delete();
    for (i = 0; i < HEADER_BYTES; i++) begin
      b = 8'($urandom);
      if (i == 2)
        b[7] = resp;
      pkt.push_back(b);
    end
  endtask

  task automatic fill_header(input logic [7:0] value);
    int i;
    pkt.delete();
    for (i = 0; i < HEADER_BYTES; i++)
      pkt.push_back(value);
  endtask

  task automatic add_label(input int len);
    pkt.push_back(8'(len));
    add_random(len);
  endtask

  // name of short labels, terminator, then type and class
  task automatic add_question(input int labels);
    int i;
    for (i = 0; i < labels; i++)
      add_label($urandom_range(1, 12));
    pkt.push_back(8'h00);
    add_random(4);
  endtask

  task automatic queue_packet();
    int          i;
    query_word_t w;
    for (i = 0; i < pkt.size(); i++) begin
      w.data = pkt[i];
      w.last = (i == pkt.size() - 1);
      query_words.push_back(w);
    end
    // every byte is offered, including those past the buffer
    fed_bytes += pkt.size();
  endtask

  task automatic directed_queries();
    // lone byte: last mark at position 0
    pkt.delete();
    pkt.push_back(8'h5A);
    queue_packet();

    // smallest valid query: all-zero header, QDCOUNT at its top, root name
    fill_header(8'h00);
    pkt[4] = 8'hFF;
    pkt[5] = 8'hFF;
    pkt.push_back(8'h00);
    pkt.push_back(8'h00); pkt.push_back(8'h01);
    pkt.push_back(8'h00); pkt.push_back(8'h01);
    queue_packet();

    // response bit already set: header passes unchanged, answer still follows
    fill_header(8'hFF);
    pkt.push_back(8'h00);
    add_random(4);
    pkt[pkt.size() - 1] = 8'hFF;
    queue_packet();

    // type and class cut short
    start_header(1'b0);
    pkt.push_back(8'h00);
    add_random(3);
    queue_packet();

    // label length points past the end: no terminator ever arrives
    start_header(1'b0);
    pkt.push_back(8'hFF);
    add_random(8);
    queue_packet();

    // terminator at 107: answer just fits; trailing bytes run past the buffer
    start_header(1'b0);
    add_label(63);
    add_label(30);
    pkt.push_back(8'h00);
    add_random(4);
    add_random(BUF_BYTES + 7 - pkt.size());
    queue_packet();

    // terminator at 108: answer would overflow the buffer
    start_header(1'b0);
    add_label(63);
    add_label(31);
    pkt.push_back(8'h00);
    add_random(4);
    queue_packet();
  endtask

  task automatic random_packet();
    int   kind;
    logic resp;
    kind = $urandom_range(99);
    resp = ($urandom_range(4) == 0);
    start_header(resp);
    if (kind < 55) begin
      // well-formed query, maybe with trailing sections that are not echoed
      add_question($urandom_range(0, 3));
      add_random($urandom_range(0, 3));
    end else if (kind < 63) begin
      // shorter than a header plus the smallest question
      pkt.delete();
      add_random($urandom_range(1, 16));
    end else if (kind < 71) begin
      // type and class incomplete
      add_question($urandom_range(0, 3));
      repeat ($urandom_range(1, 4)) void'(pkt.pop_back());
    end else if (kind < 78) begin
      // name never terminated
      add_label($urandom_range(1, 12));
      if ($urandom_range(1)) begin
        pkt.push_back(8'($urandom_range(64, 255)));
        add_random($urandom_range(1, 10));
      end
    end else if (kind < 90) begin
      pkt.delete();
      add_random($urandom_range(1, 40));
    end else if (kind < 95) begin
      // valid question, datagram longer than the buffer
      add_question($urandom_range(1, 3));
      add_random(BUF_BYTES + $urandom_range(1, 20) - pkt.size());
    end else begin
      // terminator around the overflow boundary
      add_label(63);
      add_label($urandom_range(27, 35));
      pkt.push_back(8'h00);
      add_random(4);
      add_random($urandom_range(0, 3));
    end
    queue_packet();
  endtask

  // queue at least one datagram, then more until the running total reaches target
  task automatic run_phase(input int target);
    do
      random_packet();
    while (fed_bytes < target);
  endtask

  // Hold until every byte has gone in and every word has come out, then let
  // the pipeline settle in case the last bytes produced nothing.
  task automatic wait_drained();
    @(posedge clk);
    while (query_words.size() != 0 || s_axis_tvalid || awaited_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [31:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    answer_ip = value;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // address still at its reset value of 0
    directed_queries();
    wait_drained();

    // no idling on either side for this whole stretch
    idle_pct = 0;
    write_address(32'hFFFF_FFFF);
    run_phase(TOTAL_BYTES - 45);
    wait_drained();

    idle_pct = 33;
    write_address(32'h0000_0000);
    run_phase(TOTAL_BYTES - 30);
    wait_drained();

    write_address(32'hC0A8_0401);
    run_phase(TOTAL_BYTES - 15);
    wait_drained();

    write_address($urandom);
    run_phase(TOTAL_BYTES);
    wait_drained();

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
